// ===== rtl/ssd_pkg.sv =====
// shared constants, control types and command/status structs of the shift-subtract divider
`default_nettype none

package ssd_pkg;

    // datapath width; operands are truncated or zero-extended to this width
    localparam int DATA_WIDTH  = 32;
    // width of the operand and result fields on the ports
    localparam int FIELD_WIDTH = 32;
    // step counter width, counts DATA_WIDTH-1 down to 0
    localparam int CNT_W       = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } ssd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } ssd_status_t;

endpackage

`default_nettype wire

// ===== rtl/shift_subtract_divider.sv =====
// top level of the unsigned shift-subtract divider
//
// usage
//   input channel: s_valid/s_ready carry one request of s_dividend and
//   s_divisor, both unsigned; a request is taken when both are high
//   result channel: m_valid/m_ready carry m_quotient, m_remainder and
//   m_divide_by_zero; a zero divisor returns quotient 0, remainder equal
//   to the dividend and the flag set
// sequencing
//   one request at a time: the accepting edge loads the operands, then
//   each step retires one quotient bit through a single compare-and-subtract,
//   then the answer moves to the output register once that register is
//   free; m_valid rises as the answer is written there, and s_ready
//   returns with it
// stalls
//   the output register holds a finished result while the divider takes
//   and works on the next request; a second result waits in the datapath
//   until the first is taken, and nothing is dropped
// reset
//   aresetn is synchronous, active low; it returns the controller to idle
//   and clears m_valid; operand and result registers are not reset
`default_nettype none

module shift_subtract_divider (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [ssd_pkg::FIELD_WIDTH-1:0] s_dividend,
    input  wire logic [ssd_pkg::FIELD_WIDTH-1:0] s_divisor,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [ssd_pkg::FIELD_WIDTH-1:0]      m_quotient,
    output logic [ssd_pkg::FIELD_WIDTH-1:0]      m_remainder,
    output logic                                 m_divide_by_zero
);

    // commands from the sequencer and step status back from the datapath
    ssd_pkg::ssd_cmd_t    cmd;
    ssd_pkg::ssd_status_t status;

    // state machine: idle, run DATA_WIDTH steps, hand off to the output register
    ssd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // restoring division datapath with its result register
    ssd_datapath u_datapath (
        .aclk           (aclk),
        .cmd            (cmd),
        .status         (status),
        .dividend       (s_dividend),
        .divisor        (s_divisor),
        .quotient       (m_quotient),
        .remainder      (m_remainder),
        .divide_by_zero (m_divide_by_zero)
    );

endmodule

`default_nettype wire

// ===== rtl/ssd_datapath.sv =====
// datapath: restoring shift-subtract division registers and the result register
`default_nettype none

module ssd_datapath (
    input  wire logic                          aclk,
    input  wire ssd_pkg::ssd_cmd_t             cmd,
    output ssd_pkg::ssd_status_t               status,
    input  wire logic [ssd_pkg::FIELD_WIDTH-1:0] dividend,
    input  wire logic [ssd_pkg::FIELD_WIDTH-1:0] divisor,
    output logic [ssd_pkg::FIELD_WIDTH-1:0]    quotient,
    output logic [ssd_pkg::FIELD_WIDTH-1:0]    remainder,
    output logic                               divide_by_zero
);

    logic [ssd_pkg::DATA_WIDTH-1:0]  rem_reg, rem_next;
    logic [ssd_pkg::DATA_WIDTH-1:0]  quo_reg, quo_next;
    logic [ssd_pkg::DATA_WIDTH-1:0]  dsr_reg, dsr_next;
    logic [ssd_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            dbz_reg, dbz_next;
    logic [ssd_pkg::FIELD_WIDTH-1:0] out_quo_reg, out_quo_next;
    logic [ssd_pkg::FIELD_WIDTH-1:0] out_rem_reg, out_rem_next;
    logic                            out_dbz_reg, out_dbz_next;

    logic [ssd_pkg::DATA_WIDTH:0]    shifted;
    logic [ssd_pkg::DATA_WIDTH:0]    diff;
    logic                            fits;

    // partial remainder shifted left with the next dividend bit
    assign shifted = {rem_reg, quo_reg[ssd_pkg::DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = ~diff[ssd_pkg::DATA_WIDTH];

    always_comb begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dsr_next     = dsr_reg;
        cnt_next     = cnt_reg;
        dbz_next     = dbz_reg;
        out_quo_next = out_quo_reg;
        out_rem_next = out_rem_reg;
        out_dbz_next = out_dbz_reg;
        if (cmd.load) begin
            rem_next = '0;
            quo_next = ssd_pkg::DATA_WIDTH'(dividend);
            dsr_next = ssd_pkg::DATA_WIDTH'(divisor);
            cnt_next = ssd_pkg::CNT_W'(ssd_pkg::DATA_WIDTH - 1);
            dbz_next = (ssd_pkg::DATA_WIDTH'(divisor) == '0);
        end else if (cmd.step) begin
            cnt_next = cnt_reg - ssd_pkg::CNT_W'(1);
            // zero divisor: hold the dividend untouched
            if (!dbz_reg) begin
                if (fits) begin
                    rem_next = diff[ssd_pkg::DATA_WIDTH-1:0];
                end else begin
                    rem_next = shifted[ssd_pkg::DATA_WIDTH-1:0];
                end
                quo_next = {quo_reg[ssd_pkg::DATA_WIDTH-2:0], fits};
            end
        end
        if (cmd.emit) begin
            out_dbz_next = dbz_reg;
            if (dbz_reg) begin
                out_quo_next = '0;
                out_rem_next = ssd_pkg::FIELD_WIDTH'(quo_reg);
            end else begin
                out_quo_next = ssd_pkg::FIELD_WIDTH'(quo_reg);
                out_rem_next = ssd_pkg::FIELD_WIDTH'(rem_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dsr_reg     <= dsr_next;
        cnt_reg     <= cnt_next;
        dbz_reg     <= dbz_next;
        out_quo_reg <= out_quo_next;
        out_rem_reg <= out_rem_next;
        out_dbz_reg <= out_dbz_next;
    end

    assign status.last    = (cnt_reg == '0);
    assign quotient       = out_quo_reg;
    assign remainder      = out_rem_reg;
    assign divide_by_zero = out_dbz_reg;

endmodule

`default_nettype wire

// ===== rtl/ssd_ctrl.sv =====
// controller: sequencing state machine and result valid flag
`default_nettype none

module ssd_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ssd_pkg::ssd_cmd_t         cmd,
    input  wire ssd_pkg::ssd_status_t status
);

    ssd_pkg::ctrl_state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 slot_free;

    assign slot_free = ~m_valid_reg | m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ssd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ssd_pkg::ST_RUN;
                end
            end
            ssd_pkg::ST_RUN: begin
                cmd.step = 1'b1;
                if (status.last) begin
                    state_next = ssd_pkg::ST_DONE;
                end
            end
            ssd_pkg::ST_DONE: begin
                if (slot_free) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ssd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/shift_subtract_divider_checker.sv =====
// port-level checker for the shift-subtract divider and its bind
`default_nettype none

module shift_subtract_divider_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [ssd_pkg::FIELD_WIDTH-1:0] m_quotient,
    input wire logic [ssd_pkg::FIELD_WIDTH-1:0] m_remainder,
    input wire logic                            m_divide_by_zero
);

    // a stalled result stays offered
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // one request in flight: input closes right after a request is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while dividing");

    // a fresh result never appears in the cycle after a request was taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without division steps");

    // divide by zero reports a zero quotient
    a_dbz_quotient: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_quotient == '0)
        else $error("nonzero quotient on divide by zero");

    // a returned quotient, remainder and flag never hold unknown bits
    a_known_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !$isunknown({m_quotient, m_remainder, m_divide_by_zero}))
        else $error("unknown bits in result");

endmodule

bind shift_subtract_divider shift_subtract_divider_checker u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_quotient       (m_quotient),
    .m_remainder      (m_remainder),
    .m_divide_by_zero (m_divide_by_zero)
);

`default_nettype wire

// ===== dv/shift_subtract_divider_tb.sv =====
// self-checking testbench for the shift-subtract divider: directed table, then random requests
`timescale 1ns / 100ps

module shift_subtract_divider_tb;

    localparam int FW = ssd_pkg::FIELD_WIDTH;
    localparam int DW = ssd_pkg::DATA_WIDTH;

    // number of random requests after the directed table
    localparam int RANDOM_REQUESTS = 1250;
    // drain time after the last answer, a bit more than one full division
    localparam int DRAIN_CYCLES = DW + 10;
    // watchdog, several times the slowest legal run
    localparam longint WATCHDOG_NS = 64'd8_000_000;

    localparam logic [FW-1:0] ALL_ONES = '1;
    localparam logic [FW-1:0] TOP_ONE  = {1'b1, {(FW-1){1'b0}}};

    // one answer as it leaves the result channel
    typedef struct packed {
        logic [FW-1:0] quotient;
        logic [FW-1:0] remainder;
        logic          div_zero;
    } div_answer_t;

    // one row of the directed table; typed rows carry an answer written by hand
    typedef struct packed {
        logic [FW-1:0] dividend;
        logic [FW-1:0] divisor;
        logic          typed;
        div_answer_t   answer;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 22;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // zero divisor: quotient 0, remainder is the dividend, flag set
        '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b1}},
        '{ALL_ONES,      32'h0000_0000, 1'b1, '{32'h0000_0000, ALL_ONES,      1'b1}},
        '{32'h8000_0001, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h8000_0001, 1'b1}},
        // operand extremes
        '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
        '{ALL_ONES,      32'h0000_0001, 1'b1, '{ALL_ONES,      32'h0000_0000, 1'b0}},
        // the final subtraction must not be dropped
        '{32'h0000_0003, 32'h0000_0001, 1'b1, '{32'h0000_0003, 32'h0000_0000, 1'b0}},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
        '{ALL_ONES,      ALL_ONES,      1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
        // divisor larger than the dividend
        '{32'h0000_0000, ALL_ONES,      1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
        '{32'h0000_0001, ALL_ONES,      1'b1, '{32'h0000_0000, 32'h0000_0001, 1'b0}},
        '{32'h0000_0005, 32'h0000_0007, 1'b1, '{32'h0000_0000, 32'h0000_0005, 1'b0}},
        '{32'h7FFF_FFFF, TOP_ONE,       1'b1, '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0}},
        // scaled divisor already at the top bit, no doubling possible
        '{ALL_ONES,      TOP_ONE,       1'b1, '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0}},
        // scaled divisor doubled all the way up to the top bit
        '{TOP_ONE,       32'h0000_0001, 1'b1, '{TOP_ONE,       32'h0000_0000, 1'b0}},
        '{ALL_ONES,      32'h0000_0002, 1'b1, '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0}},
        // ordinary cases, checked against the predictor
        '{32'h0000_0064, 32'h0000_0007, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{32'hDEAD_BEEF, 32'h0000_1234, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{32'h1234_5678, 32'h0000_0003, 1'b0, '{32'h0, 32'h0, 1'b0}},
        '{32'hFFFF_FFFE, ALL_ONES,      1'b0, '{32'h0, 32'h0, 1'b0}},
        '{32'h4000_0000, 32'h4000_0001, 1'b0, '{32'h0, 32'h0, 1'b0}}
    };

    // clock and synchronous active-low reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input channel
    logic          s_valid    = 1'b0;
    logic          s_ready;
    logic [FW-1:0] s_dividend = '0;
    logic [FW-1:0] s_divisor  = '0;

    // result channel
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [FW-1:0] m_quotient;
    logic [FW-1:0] m_remainder;
    logic          m_divide_by_zero;

    // answers owed by the divider, oldest first
    div_answer_t pending_answers [$];
    int          mismatch_count = 0;
    // when set, neither side inserts gaps or stalls
    bit          no_idle_phase  = 1'b0;
    int          stall_left     = 0;

    shift_subtract_divider i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_dividend       (s_dividend),
        .s_divisor        (s_divisor),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_quotient       (m_quotient),
        .m_remainder      (m_remainder),
        .m_divide_by_zero (m_divide_by_zero)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predicted answer: operands cut to the datapath width, the divisor and a
    // power-of-two weight doubled while the doubled divisor still fits, then
    // halved step by step with a subtract wherever the scaled divisor fits
    function automatic div_answer_t long_divide(logic [FW-1:0] num, logic [FW-1:0] den);
        logic [63:0] width_mask;
        logic [63:0] top_bit;
        logic [63:0] partial;
        logic [63:0] scaled;
        logic [63:0] weight;
        logic [63:0] quo;
        div_answer_t ans;
        width_mask = (DW >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << DW) - 64'd1);
        top_bit    = 64'd1 << (DW - 1);
        partial    = 64'(num) & width_mask;
        scaled     = 64'(den) & width_mask;
        weight     = 64'd1;
        quo        = 64'd0;
        if (scaled == 64'd0) begin
            ans.quotient  = '0;
            ans.remainder = partial[FW-1:0];
            ans.div_zero  = 1'b1;
            return ans;
        end
        // grow to the largest step that fits, never past the top bit
        while ((scaled & top_bit) == 64'd0 && ((scaled << 1) & width_mask) <= partial) begin
            scaled = (scaled << 1) & width_mask;
            weight = (weight << 1) & width_mask;
        end
        // one quotient bit per step, down to weight one inclusive
        while (weight != 64'd0) begin
            if (scaled <= partial) begin
                partial = partial - scaled;
                quo     = (quo + weight) & width_mask;
            end
            weight = weight >> 1;
            scaled = scaled >> 1;
        end
        ans.quotient  = quo[FW-1:0];
        ans.remainder = partial[FW-1:0];
        ans.div_zero  = 1'b0;
        return ans;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle_phase || roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    // random operand shaped to hit small values, powers of two, near-max values
    // and varying magnitudes so that the doubling stops at every bit position
    function automatic logic [FW-1:0] random_operand();
        logic [FW-1:0] value;
        case ($urandom_range(0, 6))
            0: value = FW'($urandom_range(0, 15));
            1: value = FW'($urandom) >> $urandom_range(0, FW - 1);
            2: value = TOP_ONE >> $urandom_range(0, FW - 1);
            3: value = ALL_ONES - FW'($urandom_range(0, 3));
            4: value = (TOP_ONE >> $urandom_range(0, FW - 1)) - FW'($urandom_range(0, 1));
            default: value = FW'($urandom);
        endcase
        return value;
    endfunction

    // drive one request and wait for it to be taken; valid is only lowered
    // when a gap follows, so back-to-back requests keep it high
    task automatic send_request(input logic [FW-1:0] num, input logic [FW-1:0] den,
                                input logic typed, input div_answer_t hand_answer);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_dividend <= num;
        s_divisor  <= den;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        // hand-written answers only hold for the full-width datapath
        if (typed && DW == FW) begin
            pending_answers.push_back(hand_answer);
        end else begin
            pending_answers.push_back(long_divide(num, den));
        end
    endtask

    // result side: random back-pressure and the in-order compare
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: answer with none pending: quotient %h remainder %h flag %b",
                         $time, m_quotient, m_remainder, m_divide_by_zero);
                mismatch_count++;
            end else begin
                if (m_quotient !== pending_answers[0].quotient) begin
                    $display("%0t: quotient mismatch, expected %h actual %h",
                             $time, pending_answers[0].quotient, m_quotient);
                    mismatch_count++;
                end
                if (m_remainder !== pending_answers[0].remainder) begin
                    $display("%0t: remainder mismatch, expected %h actual %h",
                             $time, pending_answers[0].remainder, m_remainder);
                    mismatch_count++;
                end
                if (m_divide_by_zero !== pending_answers[0].div_zero) begin
                    $display("%0t: divide_by_zero mismatch, expected %b actual %b",
                             $time, pending_answers[0].div_zero, m_divide_by_zero);
                    mismatch_count++;
                end
                void'(pending_answers.pop_front());
            end
        end
        // stalls start on random cycles, so they land on every phase of a division
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!no_idle_phase && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_ready <= (stall_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // stimulus and end of run
    initial begin
        logic [FW-1:0] num;
        logic [FW-1:0] den;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int row = 0; row < DIRECTED_COUNT; row++) begin
            send_request(DIRECTED_ROWS[row].dividend, DIRECTED_ROWS[row].divisor,
                         DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].answer);
        end

        // random requests; every fourth stretch runs with no idling at all
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            no_idle_phase = ((n / 150) % 4) == 3;
            num = random_operand();
            den = random_operand();
            // occasional zero divisor, and some divisors just above the dividend
            if ($urandom_range(0, 29) == 0) begin
                den = '0;
            end else if ($urandom_range(0, 19) == 0 && num != ALL_ONES) begin
                den = num + FW'($urandom_range(1, 2));
            end
            send_request(num, den, 1'b0, '0);
        end
        s_valid <= 1'b0;
        no_idle_phase = 1'b0;

        // drain, then let any late or stray answer show up
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #(WATCHDOG_NS);
        $display("%0t: timeout with %0d answers pending", $time, pending_answers.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
